/* sv/max_heap_priority_queue_unit_macros.svh */
// ---------------------------------------------------------------------------
// Max-heap priority queue: assertion macros
// Shared property shorthands for the port checker.
// ---------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// implication in the same cycle, held off during reset
`define MHPQ_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("port check failed");

// implication in the next cycle, held off during reset
`define MHPQ_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("port check failed");

// implication in the next cycle, checked through reset as well
`define MHPQ_ASSERT_NEXT_RST(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) (ant) |=> (cons)) \
        else $error("port check failed");

`endif

/* sv/mhpq_pkg.sv */
// ---------------------------------------------------------------------------
// Max-heap priority queue: package
// Operation, status and sequencer state codes shared by all modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int unsigned CFG_W    = 9;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DUP   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_DEL_TOP,
        S_DEL_LAST,
        S_DN_RD,
        S_DN_C1,
        S_DN_C2,
        S_DN_CMP
    } t_state;

    // queue status seen by its neighbours
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

`default_nettype wire

/* sv/mhpq_front.sv */
// ---------------------------------------------------------------------------
// Max-heap priority queue: front end
// Takes input words, decodes the opcode and biases the key for unsigned order.
// ---------------------------------------------------------------------------
`default_nettype none

module mhpq_front
    import mhpq_pkg::*;
#(
    parameter int unsigned KEY_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output      logic                o_ready,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire t_q_flags            i_q_flags,
    output      logic                o_push,
    output      t_op                 o_op,
    output      logic [KEY_BITS-1:0] o_bkey
);

    localparam logic [KEY_BITS-1:0] SIGN = {1'b1, {(KEY_BITS-1){1'b0}}};

    logic                r_valid;
    t_op                 r_op;
    logic [KEY_BITS-1:0] r_bkey;

    assign o_push  = r_valid && !i_q_flags.full;
    assign o_ready = !r_valid || !i_q_flags.full;
    assign o_op    = r_op;
    assign o_bkey  = r_bkey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op   <= t_op'(i_opcode);
            r_bkey <= i_key ^ SIGN;
        end
    end

endmodule

`default_nettype wire

/* sv/mhpq_queue.sv */
// ---------------------------------------------------------------------------
// Max-heap priority queue: command queue
// Two-entry FIFO between the front end and the heap engine.
// ---------------------------------------------------------------------------
`default_nettype none

module mhpq_queue
    import mhpq_pkg::*;
#(
    parameter int unsigned KEY_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire t_op                 i_op,
    input  wire logic [KEY_BITS-1:0] i_bkey,
    input  wire logic                i_pop,
    output      t_op                 o_op,
    output      logic [KEY_BITS-1:0] o_bkey,
    output      t_q_flags            o_flags
);

    t_op                 r_op  [2];
    logic [KEY_BITS-1:0] r_key [2];
    logic                r_wptr;
    logic                r_rptr;
    logic [1:0]          r_fill;

    assign o_flags.full  = (r_fill == 2'd2);
    assign o_flags.empty = (r_fill == 2'd0);
    assign o_op          = r_op[r_rptr];
    assign o_bkey        = r_key[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_op[r_wptr]  <= i_op;
            r_key[r_wptr] <= i_bkey;
        end
    end

endmodule

`default_nettype wire

/* sv/mhpq_engine.sv */
// ---------------------------------------------------------------------------
// Max-heap priority queue: heap engine
// Sequencer over the heap store (one read port, one write port): scan, sift up, sift down.
// ---------------------------------------------------------------------------
`default_nettype none

module mhpq_engine
    import mhpq_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 256,
    parameter int unsigned KEY_BITS    = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire t_q_flags            i_q_flags,
    input  wire t_op                 i_op,
    input  wire logic [KEY_BITS-1:0] i_bkey,
    output      logic                o_pop,
    output      logic                o_valid,
    input  wire logic                i_ready,
    output      logic [STATUS_W-1:0] o_status,
    output      logic                o_found,
    output      logic [KEY_BITS-1:0] o_removed,
    output      logic [COUNT_W-1:0]  o_count
);

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [KEY_BITS-1:0] SIGN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic [CW-1:0] CAP_RST  = CW'((MAX_ENTRIES < 256) ? MAX_ENTRIES : 256);
    localparam logic [CW-1:0] CAP_MAX  = CW'(MAX_ENTRIES);

    // heap store, positions 1..MAX_ENTRIES at addresses 0..MAX_ENTRIES-1
    logic [KEY_BITS-1:0] mem [MAX_ENTRIES];
    logic [KEY_BITS-1:0] r_rdata;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [KEY_BITS-1:0] mem_wd;

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_cap, n_cap;
    logic [KEY_BITS-1:0] r_top, r_last, r_cval, n_cval;
    logic [CW-1:0]       r_child, n_child;
    logic                r_ovalid, n_ovalid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_found, n_found;
    logic [KEY_BITS-1:0] r_removed, n_removed;
    logic [COUNT_W-1:0]  r_ocount;
    logic                finish;

    logic          take;
    logic [CW:0]   left_idx;
    logic          left_in;
    logic          right_in;
    logic          hit;
    logic          scan_end;
    logic          at_root;
    logic          cfg_sat;

    function automatic logic [AW-1:0] addr_of(input logic [CW:0] pos);
        logic [CW:0] a;
        a = pos - 1'b1;
        return a[AW-1:0];
    endfunction

    assign take     = (r_state == S_IDLE) && !i_q_flags.empty && !r_ovalid;
    assign left_idx = {r_i, 1'b0};
    assign left_in  = (left_idx <= {1'b0, r_count});
    assign right_in = (left_idx != {1'b0, r_count});
    assign hit      = (r_rdata == r_key);
    assign scan_end = (r_i == r_count);
    assign at_root  = (r_i <= CW'(1));
    assign cfg_sat  = ({{(32-CFG_W){1'b0}}, i_cfg_data} > 32'(MAX_ENTRIES));
    assign o_pop    = take;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_op)
                        OP_DELETE: if (r_count != '0) n_state = S_DEL_TOP;
                        OP_INSERT: begin
                            if (r_count < r_cap) begin
                                n_state = (r_count == '0) ? S_UP_RD : S_SCAN_RD;
                            end
                        end
                        OP_FIND:   if (r_count != '0) n_state = S_SCAN_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (hit) n_state = S_IDLE;
                else if (scan_end) n_state = (r_op == OP_INSERT) ? S_UP_RD : S_IDLE;
                else n_state = S_SCAN_RD;
            end
            S_UP_RD:    n_state = at_root ? S_IDLE : S_UP_CMP;
            S_UP_CMP:   n_state = (r_rdata < r_key) ? S_UP_RD : S_IDLE;
            S_DEL_TOP:  n_state = S_DEL_LAST;
            S_DEL_LAST: n_state = S_DN_RD;
            S_DN_RD:    n_state = left_in ? S_DN_C1 : S_IDLE;
            S_DN_C1:    n_state = right_in ? S_DN_C2 : S_DN_CMP;
            S_DN_C2:    n_state = S_DN_CMP;
            S_DN_CMP:   n_state = (r_last < r_cval) ? S_DN_RD : S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        mem_re    = 1'b0;
        mem_ra    = '0;
        mem_we    = 1'b0;
        mem_wa    = addr_of({1'b0, r_i});
        mem_wd    = r_key;
        n_i       = r_i;
        n_count   = r_count;
        n_cap     = r_cap;
        n_cval    = r_cval;
        n_child   = r_child;
        finish    = 1'b0;
        n_status  = ST_OK;
        n_found   = 1'b0;
        n_removed = '0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_op)
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                finish   = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re = 1'b1;
                                mem_ra = '0;
                            end
                        end
                        OP_INSERT: begin
                            if (r_count >= r_cap) begin
                                finish   = 1'b1;
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                n_count = CW'(1);
                                n_i     = CW'(1);
                            end else begin
                                n_i = CW'(1);
                            end
                        end
                        OP_FIND: begin
                            if (r_count == '0) finish = 1'b1;
                            else n_i = CW'(1);
                        end
                        default: finish = 1'b1;
                    endcase
                end
            end
            S_SCAN_RD: begin
                mem_re = 1'b1;
                mem_ra = addr_of({1'b0, r_i});
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    finish = 1'b1;
                    if (r_op == OP_INSERT) n_status = ST_DUP;
                    else n_found = 1'b1;
                end else if (scan_end) begin
                    if (r_op == OP_INSERT) begin
                        n_count = r_count + 1'b1;
                        n_i     = r_count + 1'b1;
                    end else begin
                        finish = 1'b1;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_UP_RD: begin
                if (at_root) begin
                    mem_we = 1'b1;
                    finish = 1'b1;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = addr_of({2'b0, r_i[CW-1:1]});
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_rdata < r_key) begin
                    mem_wd = r_rdata;
                    n_i    = {1'b0, r_i[CW-1:1]};
                end else begin
                    finish = 1'b1;
                end
            end
            S_DEL_TOP: begin
                mem_re = 1'b1;
                mem_ra = addr_of({1'b0, r_count});
            end
            S_DEL_LAST: begin
                n_count = r_count - 1'b1;
                n_i     = CW'(1);
            end
            S_DN_RD: begin
                if (left_in) begin
                    mem_re = 1'b1;
                    mem_ra = addr_of(left_idx);
                end else begin
                    mem_we    = (r_count != '0);
                    mem_wd    = r_last;
                    finish    = 1'b1;
                    n_removed = r_top ^ SIGN;
                end
            end
            S_DN_C1: begin
                n_cval  = r_rdata;
                n_child = left_idx[CW-1:0];
                if (right_in) begin
                    mem_re = 1'b1;
                    mem_ra = addr_of(left_idx + 1'b1);
                end
            end
            S_DN_C2: begin
                if (r_rdata > r_cval) begin
                    n_cval  = r_rdata;
                    n_child = r_child + 1'b1;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (r_last < r_cval) begin
                    mem_wd = r_cval;
                    n_i    = r_child;
                end else begin
                    mem_wd    = r_last;
                    finish    = 1'b1;
                    n_removed = r_top ^ SIGN;
                end
            end
            default: begin
                n_i = r_i;
            end
        endcase
        if (i_cfg_valid) begin
            n_cap   = cfg_sat ? CAP_MAX : CW'(i_cfg_data);
            n_count = '0;
        end
        n_ovalid = finish ? 1'b1 : (r_ovalid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cap    <= CAP_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cap    <= n_cap;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_cval  <= n_cval;
        r_child <= n_child;
        if (take) begin
            r_op  <= i_op;
            r_key <= i_bkey;
        end
        if (r_state == S_DEL_TOP)  r_top  <= r_rdata;
        if (r_state == S_DEL_LAST) r_last <= r_rdata;
        if (finish) begin
            r_status  <= n_status;
            r_found   <= n_found;
            r_removed <= n_removed;
            r_ocount  <= COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= mem[mem_ra];
    end

    assign o_valid   = r_ovalid;
    assign o_status  = r_status;
    assign o_found   = r_found;
    assign o_removed = r_removed;
    assign o_count   = r_ocount;

endmodule

`default_nettype wire

/* sv/max_heap_priority_queue_unit.sv */
// Bounded binary max-heap of signed keys. Each input word carries an opcode
// (insert, delete maximum, find, or no operation) and a key; each gives exactly
// one result word with status, found flag, removed maximum and the key count
// afterwards. Insert is refused when the heap holds capacity_in_use keys or
// already holds the key. Words are decoded in a front stage and wait in a
// two-entry queue, so the input side keeps taking words while the engine
// works, until the front stage and queue are full. The engine runs one word
// at a time over a heap store with one read and one write port and registered
// read data, so every visit of a held key takes a read state and a compare
// state. Find and insert scan the held keys; insert then sifts up, one level
// per visit. Delete maximum reads the top and last keys, then sifts down,
// reading the left and, if present, right child at each level. No-op, full
// and empty cases finish straight from the idle state. Writing the capacity
// register empties the heap; write it only when the block is idle.
// ---------------------------------------------------------------------------
// Max-heap priority queue: top level
// Stream in, stream out, one capacity register.
// ---------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_unit
    import mhpq_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 256,
    parameter int unsigned KEY_BITS    = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // capacity register write
    input  wire logic                i_cfg_valid,
    output      logic                o_cfg_ready,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    // command stream
    input  wire logic                s_axis_tvalid,
    output      logic                s_axis_tready,
    // opcode[1:0], key[KEY_BITS+1:2], zero pad
    input  wire logic [((OPCODE_W+KEY_BITS+7)/8)*8-1:0] s_axis_tdata,
    // result stream
    output      logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // status[1:0], found[2], removed_max[KEY_BITS+2:3], entry_count_out, zero pad
    output      logic [((STATUS_W+1+KEY_BITS+COUNT_W+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned OUT_W = ((STATUS_W + 1 + KEY_BITS + COUNT_W + 7) / 8) * 8;
    localparam int unsigned OUT_USED = STATUS_W + 1 + KEY_BITS + COUNT_W;

    t_q_flags            q_flags;
    logic                push, pop;
    t_op                 f_op, q_op;
    logic [KEY_BITS-1:0] f_bkey, q_bkey;
    logic [STATUS_W-1:0] e_status;
    logic                e_found;
    logic [KEY_BITS-1:0] e_removed;
    logic [COUNT_W-1:0]  e_count;

    // register writes are always taken at once
    assign o_cfg_ready = 1'b1;

    mhpq_front #(.KEY_BITS(KEY_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_opcode  (s_axis_tdata[OPCODE_W-1:0]),
        .i_key     (s_axis_tdata[OPCODE_W+KEY_BITS-1:OPCODE_W]),
        .i_q_flags (q_flags),
        .o_push    (push),
        .o_op      (f_op),
        .o_bkey    (f_bkey)
    );

    mhpq_queue #(.KEY_BITS(KEY_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .i_bkey  (f_bkey),
        .i_pop   (pop),
        .o_op    (q_op),
        .o_bkey  (q_bkey),
        .o_flags (q_flags)
    );

    mhpq_engine #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_flags   (q_flags),
        .i_op        (q_op),
        .i_bkey      (q_bkey),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (e_status),
        .o_found     (e_found),
        .o_removed   (e_removed),
        .o_count     (e_count)
    );

    assign m_axis_tdata = {{(OUT_W-OUT_USED){1'b0}}, e_count, e_removed, e_found, e_status};

endmodule

`default_nettype wire

/* sv/mhpq_checker.sv */
// ---------------------------------------------------------------------------
// Max-heap priority queue: port checker
// Watches the top-level ports; bound to the top level below.
// ---------------------------------------------------------------------------
`default_nettype none

`include "max_heap_priority_queue_unit_macros.svh"

module mhpq_checker
    import mhpq_pkg::*;
#(
    parameter int unsigned KEY_BITS = 32
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [((STATUS_W+1+KEY_BITS+COUNT_W+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned CNT_LO = STATUS_W + 1 + KEY_BITS;

    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;

    assign status = m_axis_tdata[STATUS_W-1:0];
    assign found  = m_axis_tdata[STATUS_W];
    assign count  = m_axis_tdata[CNT_LO+COUNT_W-1:CNT_LO];

    // a waiting result word holds
    `MHPQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    // an empty-heap refusal reports no keys held
    `MHPQ_ASSERT_NOW(a_empty_count, m_axis_tvalid && (status == ST_EMPTY), count == '0)
    // a hit on find never carries an error status
    `MHPQ_ASSERT_NOW(a_found_ok, m_axis_tvalid && found, status == ST_OK)
    // no result is offered straight out of reset
    `MHPQ_ASSERT_NEXT_RST(a_rst_quiet, !i_rst_n, !m_axis_tvalid)

endmodule

bind max_heap_priority_queue_unit mhpq_checker #(.KEY_BITS(KEY_BITS)) u_checker (.*);

`default_nettype wire
